// File: hw/rtl/bmpd_pkg.sv
// ============================================================================
// bmpd_pkg: shared types and constants of the banked memory map decoder
// Holds the item and result layouts, the bus function codes, the decoded
// port bytes and the keyboard row lookup.
// ============================================================================
package bmpd_pkg;

    // Field widths.
    localparam int FUNC_W   = 3;
    localparam int ADDR_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int PAGE_W   = 3;
    localparam int OFFS_W   = 14;
    localparam int BORDER_W = 3;
    localparam int ROW_W    = 3;
    localparam int KEY_ROWS = 8;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Bus function codes carried in tuser.
    localparam logic [FUNC_W-1:0] FUNC_MEM_RD   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_MEM_WR   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_IO_RD    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_IO_WR    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_KEY = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_JOY = 3'd5;

    // Port address bytes.
    localparam logic [BYTE_W-1:0] PORT_ULA_LO   = 8'hFE;
    localparam logic [BYTE_W-1:0] PORT_JOY_LO   = 8'h1F;
    localparam logic [BYTE_W-1:0] PORT_PAGE_LO  = 8'hFD;
    localparam logic [BYTE_W-1:0] PORT_PAGE_HI  = 8'h7F;
    localparam logic [BYTE_W-1:0] PORT_PLUS_HI  = 8'h1F;
    localparam logic [BYTE_W-1:0] PORT_ALL_ROWS = 8'h00;

    // Fixed RAM pages of the middle two 16K windows.
    localparam logic [PAGE_W-1:0] PAGE_WIN1 = 3'd5;
    localparam logic [PAGE_W-1:0] PAGE_WIN2 = 3'd2;

    // Reset values.
    localparam logic [BYTE_W-1:0]   KEY_ROW_RESET = 8'h1F;
    localparam logic [BYTE_W-1:0]   JOY_RESET     = 8'h1F;
    localparam logic [BORDER_W-1:0] BORDER_RESET  = 3'd7;

    // One accepted bus item.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data;
        logic              ear_level;
        logic [BYTE_W-1:0] floating_bus;
    } t_item;

    // One result item.
    typedef struct packed {
        logic                mem_access;
        logic                mem_write;
        logic                mem_is_rom;
        logic [PAGE_W-1:0]   mem_page;
        logic [OFFS_W-1:0]   mem_offset;
        logic [BYTE_W-1:0]   read_data;
        logic [BORDER_W-1:0] border_colour;
        logic                speaker_level;
        logic                mic_level;
        logic                video_page_select;
        logic                special_mode;
    } t_result;

    // Keyboard half-row selected by the port high byte; unknown bytes act as row 0.
    function automatic logic [ROW_W-1:0] row_index(input logic [BYTE_W-1:0] hi);
        logic [ROW_W-1:0] row;
        case (hi)
            8'hFE:   row = 3'd0;
            8'hFD:   row = 3'd1;
            8'hFB:   row = 3'd2;
            8'hF7:   row = 3'd3;
            8'hEF:   row = 3'd4;
            8'hDF:   row = 3'd5;
            8'hBF:   row = 3'd6;
            8'h7F:   row = 3'd7;
            default: row = 3'd0;
        endcase
        return row;
    endfunction

endpackage

// File: hw/rtl/bmpd_in_stage.sv
// ============================================================================
// bmpd_in_stage: input register of the decoder
// Captures one item from the slave stream and holds it until the decode
// logic can pass its result on to the output register.
// ============================================================================
module bmpd_in_stage
    import bmpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic [FUNC_W-1:0]     i_tuser,
    input  logic                  i_advance,
    output logic                  o_ready,
    output logic                  o_valid,
    output t_item                 o_item
);

    logic  r_valid;
    t_item r_item;

    // The register frees up when its item moves on in the same cycle.
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, unpacked from tdata lowest field first.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.func         <= i_tuser;
            r_item.address      <= i_tdata[15:0];
            r_item.data         <= i_tdata[23:16];
            r_item.ear_level    <= i_tdata[24];
            r_item.floating_bus <= i_tdata[32:25];
        end
    end

endmodule

// File: hw/rtl/bmpd_core.sv
// ============================================================================
// bmpd_core: address map, port decode and machine state
// Works out the result of the held item from the current latches and
// commits the updated latches and keyboard rows when the item moves on.
// ============================================================================
module bmpd_core
    import bmpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_advance,
    output t_result o_result
);

    // Machine state.
    logic [BYTE_W-1:0]   r_key_rows [KEY_ROWS];
    logic [BYTE_W-1:0]   r_joy;
    logic [BORDER_W-1:0] r_border;
    logic                r_speaker;
    logic                r_mic;
    logic [PAGE_W-1:0]   r_ram_bank;
    logic                r_rom_low;
    logic                r_rom_high;
    logic                r_video;
    logic                r_lock;
    logic                r_mode;

    logic [BYTE_W-1:0]   n_key_rows [KEY_ROWS];
    logic [BYTE_W-1:0]   n_joy;
    logic [BORDER_W-1:0] n_border;
    logic                n_speaker;
    logic                n_mic;
    logic [PAGE_W-1:0]   n_ram_bank;
    logic                n_rom_low;
    logic                n_rom_high;
    logic                n_video;
    logic                n_lock;
    logic                n_mode;

    logic [BYTE_W-1:0] port_lo;
    logic [BYTE_W-1:0] port_hi;
    logic [1:0]        window;
    logic              map_is_rom;
    logic [PAGE_W-1:0] map_page;
    logic [ROW_W-1:0]  sel_row;
    logic [BYTE_W-1:0] all_rows;
    t_result           res;

    assign port_lo = i_item.address[7:0];
    assign port_hi = i_item.address[15:8];
    assign window  = i_item.address[15:14];
    assign sel_row = row_index(port_hi);

    // Page selection for the four 16K windows.
    always_comb begin
        map_is_rom = (window == 2'd0);
        case (window)
            2'd0:    map_page = {1'b0, r_rom_high, r_rom_low};
            2'd1:    map_page = PAGE_WIN1;
            2'd2:    map_page = PAGE_WIN2;
            default: map_page = r_ram_bank;
        endcase
    end

    // AND of all keyboard rows for the all-rows read.
    always_comb begin
        all_rows = '1;
        for (int i = 0; i < KEY_ROWS; i++) begin
            all_rows &= r_key_rows[i];
        end
    end

    // Decode of the held item into its result and the next state.
    always_comb begin
        n_key_rows = r_key_rows;
        n_joy      = r_joy;
        n_border   = r_border;
        n_speaker  = r_speaker;
        n_mic      = r_mic;
        n_ram_bank = r_ram_bank;
        n_rom_low  = r_rom_low;
        n_rom_high = r_rom_high;
        n_video    = r_video;
        n_lock     = r_lock;
        n_mode     = r_mode;
        res        = '0;

        case (i_item.func)
            FUNC_MEM_RD: begin
                res.mem_access = 1'b1;
                res.mem_is_rom = map_is_rom;
                res.mem_page   = map_page;
                res.mem_offset = i_item.address[OFFS_W-1:0];
            end
            FUNC_MEM_WR: begin
                // Writes into the ROM window are dropped but still described.
                res.mem_access = !map_is_rom;
                res.mem_write  = !map_is_rom;
                res.mem_is_rom = map_is_rom;
                res.mem_page   = map_page;
                res.mem_offset = i_item.address[OFFS_W-1:0];
            end
            FUNC_IO_RD: begin
                if (port_lo == PORT_ULA_LO) begin
                    if (port_hi == PORT_ALL_ROWS) begin
                        res.read_data = all_rows;
                    end else begin
                        // The EAR level is stored into bit 6 of the row it reads.
                        n_key_rows[sel_row][6] = i_item.ear_level;
                        res.read_data = {r_key_rows[sel_row][7], i_item.ear_level,
                                         r_key_rows[sel_row][5:0]};
                    end
                end else if (port_lo == PORT_JOY_LO) begin
                    res.read_data = r_joy;
                end else begin
                    res.read_data = i_item.floating_bus;
                end
            end
            FUNC_IO_WR: begin
                if (port_lo == PORT_ULA_LO) begin
                    n_border  = i_item.data[2:0];
                    n_mic     = i_item.data[3];
                    n_speaker = i_item.data[4];
                end else if (port_lo == PORT_PAGE_LO) begin
                    if (port_hi == PORT_PAGE_HI) begin
                        // Paging latch, frozen once the lock bit is set.
                        if (!r_lock) begin
                            n_ram_bank = i_item.data[2:0];
                            n_video    = i_item.data[3];
                            n_rom_low  = i_item.data[4];
                            n_lock     = i_item.data[5];
                        end
                    end else if (port_hi == PORT_PLUS_HI) begin
                        n_mode     = i_item.data[0];
                        n_rom_high = i_item.data[2];
                    end
                end
            end
            FUNC_LOAD_KEY: begin
                n_key_rows[i_item.address[ROW_W-1:0]] = i_item.data;
            end
            FUNC_LOAD_JOY: begin
                n_joy = i_item.data;
            end
            default: begin
            end
        endcase

        // Reported latches show the state after this item.
        res.border_colour     = n_border;
        res.speaker_level     = n_speaker;
        res.mic_level         = n_mic;
        res.video_page_select = n_video;
        res.special_mode      = n_mode;
    end

    assign o_result = res;

    // State registers, committed as the item moves to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_ROWS; i++) begin
                r_key_rows[i] <= KEY_ROW_RESET;
            end
            r_joy      <= JOY_RESET;
            r_border   <= BORDER_RESET;
            r_speaker  <= 1'b0;
            r_mic      <= 1'b0;
            r_ram_bank <= '0;
            r_rom_low  <= 1'b0;
            r_rom_high <= 1'b0;
            r_video    <= 1'b0;
            r_lock     <= 1'b0;
            r_mode     <= 1'b0;
        end else if (i_advance) begin
            r_key_rows <= n_key_rows;
            r_joy      <= n_joy;
            r_border   <= n_border;
            r_speaker  <= n_speaker;
            r_mic      <= n_mic;
            r_ram_bank <= n_ram_bank;
            r_rom_low  <= n_rom_low;
            r_rom_high <= n_rom_high;
            r_video    <= n_video;
            r_lock     <= n_lock;
            r_mode     <= n_mode;
        end
    end

endmodule

// File: hw/rtl/bmpd_out_stage.sv
// ============================================================================
// bmpd_out_stage: result register of the decoder
// Holds one result item for the master stream and packs it into tdata.
// ============================================================================
module bmpd_out_stage
    import bmpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_result                i_result,
    input  logic                   i_tready,
    output logic                   o_ready,
    output logic                   o_tvalid,
    output logic [OUT_TDATA_W-1:0] o_tdata
);

    logic    r_valid;
    t_result r_result;

    // A new result may enter when the register is empty or being emptied.
    assign o_ready  = !r_valid || i_tready;
    assign o_tvalid = r_valid;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    // Pack lowest field first, zero filled to whole bytes.
    assign o_tdata = {5'd0,
                      r_result.special_mode,
                      r_result.video_page_select,
                      r_result.mic_level,
                      r_result.speaker_level,
                      r_result.border_colour,
                      r_result.read_data,
                      r_result.mem_offset,
                      r_result.mem_page,
                      r_result.mem_is_rom,
                      r_result.mem_write,
                      r_result.mem_access};

endmodule

// File: hw/rtl/banked_memory_map_and_port_decode.sv
// ============================================================================
// banked_memory_map_and_port_decode: paged memory map and port decoder
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: func; tdata: address, data, ear_level,
//                        floating_bus
//   m_axis    out        tdata: memory page and offset, read byte, latches
//
// One item is accepted per cycle unless a stalled result keeps the input
// register full; its result is offered once it has passed the input register
// into the result register.
// Reset is synchronous and active low; it empties both registers and loads
// the latches and keyboard rows with their power-up values.
// A stalled result holds in the result register while the input register
// still takes one more item.
// ============================================================================
module banked_memory_map_and_port_decode
    import bmpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata from bit 0: address[15:0], data[23:16], ear_level[24],
    // floating_bus[32:25], zero fill[39:33]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser from bit 0: func[2:0]
    input  logic [FUNC_W-1:0]      s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata from bit 0: mem_access[0], mem_write[1], mem_is_rom[2],
    // mem_page[5:3], mem_offset[19:6], read_data[27:20], border_colour[30:28],
    // speaker_level[31], mic_level[32], video_page_select[33],
    // special_mode[34], zero fill[39:35]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic    in_valid;
    t_item   in_item;
    logic    out_ready;
    logic    advance;
    t_result result;

    // The held item moves on when the result register can take it.
    assign advance = in_valid && out_ready;

    bmpd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_tdata   (s_axis_tdata),
        .i_tuser   (s_axis_tuser),
        .i_advance (advance),
        .o_ready   (s_axis_tready),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    bmpd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (in_item),
        .i_advance (advance),
        .o_result  (result)
    );

    bmpd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (result),
        .i_tready (m_axis_tready),
        .o_ready  (out_ready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata)
    );

endmodule

// File: hw/rtl/bmpd_checker.sv
// ============================================================================
// bmpd_checker: port-level checks of the decoder
// Watches the stream ports of the top level and flags results that break
// the decoder's rules; bound to every instance of the top level.
// ============================================================================
module bmpd_checker
    import bmpd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A page store write is always a RAM access.
    a_write_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0] && !m_axis_tdata[2])
        else $error("page store write outside RAM");

    // Memory accesses never return a port byte.
    a_mem_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[27:20] == 8'h00)
        else $error("memory access carries a port read byte");

    // With the result register empty the input side is always open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty result register");

endmodule

bind banked_memory_map_and_port_decode bmpd_checker u_bmpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: test/tb.sv
// ============================================================================
// tb: testbench of the banked memory map and port decoder
// A short directed sequence covers the memory windows, ROM write dropping,
// every port decode and the paging lock. Then about 650 random bus items are
// sent in bursts against a receiver that stalls on its own pattern, with one
// long hold-off that fills the block. Each result is compared field by field
// with the prediction of a behavioral copy of the decoder kept in the
// testbench.
// ============================================================================
module tb;
    import bmpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Function codes the block treats as no operation.
    localparam logic [FUNC_W-1:0] FUNC_NOP_A = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_NOP_B = 3'd7;

    // Sound chip port high bytes; both decode to nothing in this block.
    localparam logic [BYTE_W-1:0] PORT_AY_SEL_HI  = 8'hFF;
    localparam logic [BYTE_W-1:0] PORT_AY_DATA_HI = 8'hBF;

    // Bit positions inside the written and loaded bytes.
    localparam int EAR_BIT   = 6;
    localparam int MIC_BIT   = 3;
    localparam int SPK_BIT   = 4;
    localparam int VIDEO_BIT = 3;
    localparam int ROM_LO_BIT = 4;
    localparam int LOCK_BIT  = 5;
    localparam int MODE_BIT  = 0;
    localparam int ROM_HI_BIT = 2;

    // 16K windows selected by address bits 15..14.
    localparam logic [1:0] WIN_ROM  = 2'd0;
    localparam logic [1:0] WIN_RAM1 = 2'd1;
    localparam logic [1:0] WIN_RAM2 = 2'd2;

    localparam int RANDOM_ITEMS = 620;
    localparam int FILL_BURST   = 30;
    localparam int HOLD_CYCLES  = 64;
    localparam int RX_MODE_SPAN = 150;

    typedef enum int {RX_FLOW, RX_RANDOM, RX_SPARSE, RX_BEAT} t_rx_mode;

    // ------------------------------------------------------------------------
    // Behavioral copy of the decoder and the queue of outcomes it predicts.
    // ------------------------------------------------------------------------
    class paging_decoder_model;
        logic [BYTE_W-1:0]   key_rows [KEY_ROWS];
        logic [BYTE_W-1:0]   joystick;
        logic [BORDER_W-1:0] border;
        logic                speaker;
        logic                mic;
        logic [PAGE_W-1:0]   ram_bank;
        logic                rom_low;
        logic                rom_high;
        logic                video;
        logic                locked;
        logic                mode;
        t_result             expected_outcomes[$];
        int                  n_mismatch;

        function new();
            foreach (key_rows[k]) key_rows[k] = KEY_ROW_RESET;
            joystick   = JOY_RESET;
            border     = BORDER_RESET;
            speaker    = 1'b0;
            mic        = 1'b0;
            ram_bank   = '0;
            rom_low    = 1'b0;
            rom_high   = 1'b0;
            video      = 1'b0;
            locked     = 1'b0;
            mode       = 1'b0;
            n_mismatch = 0;
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        // Prints one line per mismatch and counts it.
        task report(string what, longint unsigned got, longint unsigned want);
            n_mismatch++;
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        endtask

        // Works out the outcome of one accepted bus item and updates the latches.
        function void accept_access(t_item it);
            t_result           r;
            logic [BYTE_W-1:0] lo;
            logic [BYTE_W-1:0] hi;
            int                row;
            r  = '0;
            lo = it.address[7:0];
            hi = it.address[15:8];
            case (it.func)
                FUNC_MEM_RD, FUNC_MEM_WR: begin
                    r.mem_offset = it.address[OFFS_W-1:0];
                    case (it.address[15:14])
                        WIN_ROM: begin
                            r.mem_is_rom = 1'b1;
                            r.mem_page   = {1'b0, rom_high, rom_low};
                        end
                        WIN_RAM1: r.mem_page = PAGE_WIN1;
                        WIN_RAM2: r.mem_page = PAGE_WIN2;
                        default:  r.mem_page = ram_bank;
                    endcase
                    // Writes into the ROM window are dropped.
                    r.mem_access = (it.func == FUNC_MEM_RD) || !r.mem_is_rom;
                    r.mem_write  = (it.func == FUNC_MEM_WR) && !r.mem_is_rom;
                end
                FUNC_IO_RD: begin
                    if (lo == PORT_ULA_LO && hi == PORT_ALL_ROWS) begin
                        r.read_data = '1;
                        foreach (key_rows[k]) r.read_data &= key_rows[k];
                    end else if (lo == PORT_ULA_LO) begin
                        // A half-row is picked by the single low bit in the high
                        // byte; any other byte falls back to row 0.
                        row = 0;
                        for (int k = 0; k < KEY_ROWS; k++) begin
                            if (hi == ~(8'd1 << k)) row = k;
                        end
                        key_rows[row][EAR_BIT] = it.ear_level;
                        r.read_data = key_rows[row];
                    end else if (lo == PORT_JOY_LO) begin
                        r.read_data = joystick;
                    end else begin
                        r.read_data = it.floating_bus;
                    end
                end
                FUNC_IO_WR: begin
                    if (lo == PORT_ULA_LO) begin
                        border  = it.data[BORDER_W-1:0];
                        mic     = it.data[MIC_BIT];
                        speaker = it.data[SPK_BIT];
                    end else if (lo == PORT_PAGE_LO && hi == PORT_PAGE_HI) begin
                        if (!locked) begin
                            ram_bank = it.data[PAGE_W-1:0];
                            video    = it.data[VIDEO_BIT];
                            rom_low  = it.data[ROM_LO_BIT];
                            locked   = it.data[LOCK_BIT];
                        end
                    end else if (lo == PORT_PAGE_LO && hi == PORT_PLUS_HI) begin
                        mode     = it.data[MODE_BIT];
                        rom_high = it.data[ROM_HI_BIT];
                    end
                end
                FUNC_LOAD_KEY: key_rows[it.address[ROW_W-1:0]] = it.data;
                FUNC_LOAD_JOY: joystick = it.data;
                default: ;
            endcase
            r.border_colour     = border;
            r.speaker_level     = speaker;
            r.mic_level         = mic;
            r.video_page_select = video;
            r.special_mode      = mode;
            expected_outcomes.push_back(r);
        endfunction

        // Compares one result item with the oldest predicted outcome.
        task check_outcome(logic [OUT_TDATA_W-1:0] td);
            t_result want;
            if (expected_outcomes.size() == 0) begin
                report("unexpected result", td, 0);
            end else begin
                want = expected_outcomes.pop_front();
                if (td[0] !== want.mem_access)   report("mem_access", td[0], want.mem_access);
                if (td[1] !== want.mem_write)    report("mem_write", td[1], want.mem_write);
                if (td[2] !== want.mem_is_rom)   report("mem_is_rom", td[2], want.mem_is_rom);
                if (td[5:3] !== want.mem_page)   report("mem_page", td[5:3], want.mem_page);
                if (td[19:6] !== want.mem_offset) report("mem_offset", td[19:6], want.mem_offset);
                if (td[27:20] !== want.read_data) report("read_data", td[27:20], want.read_data);
                if (td[30:28] !== want.border_colour)
                    report("border_colour", td[30:28], want.border_colour);
                if (td[31] !== want.speaker_level)
                    report("speaker_level", td[31], want.speaker_level);
                if (td[32] !== want.mic_level) report("mic_level", td[32], want.mic_level);
                if (td[33] !== want.video_page_select)
                    report("video_page_select", td[33], want.video_page_select);
                if (td[34] !== want.special_mode)
                    report("special_mode", td[34], want.special_mode);
                if (td[39:35] !== '0) report("zero fill", td[39:35], 0);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test.
    // ------------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [FUNC_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic     hold_req = 1'b0;
    logic     hold_done = 1'b0;
    int       hold_left = 0;
    int       rx_tick = 0;
    t_rx_mode rx_mode = RX_FLOW;

    paging_decoder_model decoder = new();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    banked_memory_map_and_port_decode dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Sender tasks.
    // ------------------------------------------------------------------------

    // Offers one item and returns at the edge where it is taken.
    task automatic send_item(t_item it);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {7'd0, it.floating_bus, it.ear_level, it.data, it.address};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drive(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] address,
                         logic [BYTE_W-1:0] data, logic ear, logic [BYTE_W-1:0] fbus);
        t_item it;
        it.func         = func;
        it.address      = address;
        it.data         = data;
        it.ear_level    = ear;
        it.floating_bus = fbus;
        send_item(it);
    endtask

    task automatic pause(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Random bus item, weighted toward the decoded ports. Locking writes to
    // the paging port are only let through when allow_lock is set.
    function automatic t_item random_item(bit allow_lock);
        t_item it;
        int    pick;
        int    sel;
        it.address      = ADDR_W'($urandom);
        it.data         = BYTE_W'($urandom);
        it.ear_level    = 1'($urandom);
        it.floating_bus = BYTE_W'($urandom);
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        if (pick < 30)      it.func = FUNC_MEM_RD;
        else if (pick < 45) it.func = FUNC_MEM_WR;
        else if (pick < 65) it.func = FUNC_IO_RD;
        else if (pick < 82) it.func = FUNC_IO_WR;
        else if (pick < 90) it.func = FUNC_LOAD_KEY;
        else if (pick < 96) it.func = FUNC_LOAD_JOY;
        else                it.func = $urandom_range(0, 1) ? FUNC_NOP_A : FUNC_NOP_B;
        if (it.func == FUNC_IO_RD) begin
            if (sel < 5) begin
                it.address = {~(8'd1 << $urandom_range(0, 7)), PORT_ULA_LO};
            end else if (sel == 5) begin
                it.address = {PORT_ALL_ROWS, PORT_ULA_LO};
            end else if (sel == 6) begin
                it.address[7:0] = PORT_ULA_LO;
            end else if (sel == 7) begin
                it.address[7:0] = PORT_JOY_LO;
            end else if (sel == 8) begin
                it.address = {$urandom_range(0, 1) ? PORT_AY_SEL_HI : PORT_AY_DATA_HI,
                              PORT_PAGE_LO};
            end
        end else if (it.func == FUNC_IO_WR) begin
            if (sel < 3) begin
                it.address[7:0] = PORT_ULA_LO;
            end else if (sel < 6) begin
                it.address = {PORT_PAGE_HI, PORT_PAGE_LO};
            end else if (sel < 8) begin
                it.address = {PORT_PLUS_HI, PORT_PAGE_LO};
            end else if (sel == 8) begin
                it.address = {$urandom_range(0, 1) ? PORT_AY_SEL_HI : PORT_AY_DATA_HI,
                              PORT_PAGE_LO};
            end
            if (!allow_lock && it.address == {PORT_PAGE_HI, PORT_PAGE_LO})
                it.data[LOCK_BIT] = 1'b0;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        int burst;
        int gap;
        bit filled;
        sent   = 0;
        filled = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Memory windows at their edges, a dropped ROM write, and the ULA port.
        drive(FUNC_MEM_RD, 16'h0000, 8'h00, 1'b0, 8'h00);
        drive(FUNC_MEM_RD, 16'hFFFF, 8'hFF, 1'b1, 8'hFF);
        drive(FUNC_MEM_WR, 16'h3FFF, 8'hA5, 1'b0, 8'h00);
        drive(FUNC_MEM_WR, 16'h4000, 8'h5A, 1'b1, 8'h11);
        drive(FUNC_MEM_RD, 16'h8000, 8'h00, 1'b0, 8'h22);
        drive(FUNC_IO_WR,  16'hFFFE, 8'hFF, 1'b0, 8'h00);
        drive(FUNC_IO_WR,  16'h00FE, 8'h00, 1'b1, 8'hFF);
        // Keyboard rows: load, read one row with EAR, read all rows, odd high byte.
        drive(FUNC_LOAD_KEY, 16'h0003, 8'h00, 1'b0, 8'h00);
        drive(FUNC_LOAD_KEY, 16'hFFFF, 8'hFF, 1'b0, 8'h00);
        drive(FUNC_IO_RD,  16'hFEFE, 8'h00, 1'b1, 8'h33);
        drive(FUNC_IO_RD,  16'h7FFE, 8'h00, 1'b0, 8'h44);
        drive(FUNC_IO_RD,  16'h00FE, 8'h00, 1'b1, 8'h55);
        drive(FUNC_IO_RD,  16'h12FE, 8'h00, 1'b1, 8'h66);
        // Joystick, the sound chip port as floating bus, and the paging latches.
        drive(FUNC_LOAD_JOY, 16'h0000, 8'hA5, 1'b0, 8'h00);
        drive(FUNC_IO_RD,  16'h001F, 8'h00, 1'b0, 8'h77);
        drive(FUNC_IO_RD,  16'hFFFD, 8'h00, 1'b1, 8'h5A);
        drive(FUNC_IO_WR,  16'hBFFD, 8'hFF, 1'b0, 8'h00);
        drive(FUNC_IO_WR,  16'h1FFD, 8'h05, 1'b0, 8'h00);
        drive(FUNC_IO_WR,  16'h7FFD, 8'h1F, 1'b0, 8'h00);
        drive(FUNC_MEM_RD, 16'h1234, 8'h00, 1'b0, 8'h00);
        drive(FUNC_MEM_WR, 16'hC000, 8'h00, 1'b0, 8'h00);
        drive(FUNC_NOP_A,  16'hFFFF, 8'hFF, 1'b1, 8'hFF);
        drive(FUNC_NOP_B,  16'hC0DE, 8'h3C, 1'b0, 8'hC3);

        // Random bursts; once, the receiver holds off while a long burst goes on.
        while (sent < RANDOM_ITEMS) begin
            if (!filled && sent >= RANDOM_ITEMS / 2) begin
                filled = 1'b1;
                hold_req <= 1'b1;
                burst = FILL_BURST;
            end else begin
                burst = $urandom_range(1, 24);
            end
            repeat (burst) send_item(random_item(1'b0));
            sent += burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) pause(gap);
        end

        // Paging lock: set it, try to move the bank, then random traffic locked.
        drive(FUNC_IO_WR,  16'h7FFD, 8'h2B, 1'b0, 8'h00);
        drive(FUNC_MEM_RD, 16'hC001, 8'h00, 1'b0, 8'h00);
        drive(FUNC_IO_WR,  16'h7FFD, 8'h17, 1'b0, 8'h00);
        drive(FUNC_MEM_RD, 16'hFFFE, 8'h00, 1'b0, 8'h00);
        drive(FUNC_MEM_RD, 16'h0001, 8'h00, 1'b0, 8'h00);
        repeat (25) send_item(random_item(1'b1));
        s_axis_tvalid <= 1'b0;

        while (decoder.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (decoder.n_mismatch == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: ready follows a mode that changes now and then, plus one long
    // hold-off when the stimulus asks for it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % RX_MODE_SPAN == 0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FLOW:   m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    // Accepted items feed the prediction; accepted results are checked.
    always @(posedge i_clk) begin
        t_item it;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            it.func         = s_axis_tuser;
            it.address      = s_axis_tdata[15:0];
            it.data         = s_axis_tdata[23:16];
            it.ear_level    = s_axis_tdata[24];
            it.floating_bus = s_axis_tdata[32:25];
            decoder.accept_access(it);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) decoder.check_outcome(m_axis_tdata);
    end

    // Run limit.
    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
